// ===== rtl/gml_pkg.sv =====
// ----------------------------------------------------------------------------
// gml_pkg
// shared widths, character codes, scan record and scaling tables for the
// g1 move-line parser
// ----------------------------------------------------------------------------
package gml_pkg;

  localparam int unsigned NUMBER_CHARS = 5;
  localparam int unsigned AXES         = 3;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 31;
  localparam int unsigned ACC_W   = 27;
  localparam int unsigned FRAC_W  = 3;
  localparam int unsigned MAG_W   = 30;
  localparam int unsigned MULT_W  = 32;
  localparam int unsigned PROD_W  = ACC_W + 1 + MULT_W;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned HALF_W  = 9;
  localparam int unsigned COL_W   = 2;

  localparam logic [MAG_W-1:0]  MAG_MAX  = '1;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 3'd7;
  localparam logic [COL_W-1:0]  COL_SAT  = 2'd3;
  localparam logic [COL_W-1:0]  COL_ONE  = 2'd1;

  localparam logic [BYTE_W-1:0] CHAR_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_ONE    = 8'h31;
  localparam logic [BYTE_W-1:0] CHAR_X      = 8'h58;
  localparam logic [BYTE_W-1:0] CHAR_Y      = 8'h59;
  localparam logic [BYTE_W-1:0] CHAR_Z      = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_E      = 8'h45;
  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_VT     = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF     = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_POINT  = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_LC_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LC_Z   = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  localparam logic [BYTE_W-1:0] AXIS_LETTER [AXES] = '{CHAR_X, CHAR_Y, CHAR_Z};

  typedef struct packed {
    logic              seen;
    logic              negative;
    logic [ACC_W-1:0]  accum;
    logic [FRAC_W-1:0] frac;
  } axis_num_t;

  function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CHAR_LC_A && c <= CHAR_LC_Z) r = c - CASE_OFFSET;
    return r;
  endfunction

  // multiplier: power of ten up to four fraction digits, reciprocal beyond
  function automatic logic [MULT_W-1:0] scale_mult(input logic [FRAC_W-1:0] f);
    logic [MULT_W-1:0] m;
    case (f)
      3'd0:    m = 32'd10000;
      3'd1:    m = 32'd1000;
      3'd2:    m = 32'd100;
      3'd3:    m = 32'd10;
      3'd4:    m = 32'd1;
      3'd5:    m = 32'hCCCC_CCCD;
      3'd6:    m = 32'h51EB_851F;
      3'd7:    m = 32'h1062_4DD3;
      default: m = 32'd1;
    endcase
    return m;
  endfunction

  function automatic logic [SHIFT_W-1:0] scale_shift(input logic [FRAC_W-1:0] f);
    logic [SHIFT_W-1:0] s;
    case (f)
      3'd5:    s = 6'd35;
      3'd6:    s = 6'd37;
      3'd7:    s = 6'd38;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  // half of the divisor, for rounding half away from zero
  function automatic logic [HALF_W-1:0] round_half(input logic [FRAC_W-1:0] f);
    logic [HALF_W-1:0] h;
    case (f)
      3'd5:    h = 9'd5;
      3'd6:    h = 9'd50;
      3'd7:    h = 9'd500;
      default: h = 9'd0;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/gml_in_if.sv =====
// ----------------------------------------------------------------------------
// gml_in_if
// text channel: one character beat with its end-of-line mark
// ----------------------------------------------------------------------------
interface gml_in_if;
  import gml_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_line;

  modport source (output valid, output text_byte, output end_of_line, input ready);
  modport sink   (input valid, input text_byte, input end_of_line, output ready);
endinterface

// ===== rtl/gml_out_if.sv =====
// ----------------------------------------------------------------------------
// gml_out_if
// move channel: end point and flags of one g1 line per beat
// ----------------------------------------------------------------------------
interface gml_out_if;
  import gml_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic signed [POS_W-1:0] z_pos;
  logic                    new_layer;
  logic                    extruding;

  modport source (output valid, output x_pos, output y_pos, output z_pos,
                  output new_layer, output extruding, input ready);
  modport sink   (input valid, input x_pos, input y_pos, input z_pos,
                  input new_layer, input extruding, output ready);
endinterface

// ===== rtl/gml_axis_scan.sv =====
// ----------------------------------------------------------------------------
// gml_axis_scan
// per-axis number scanner: finds the axis letter and accumulates the
// following window of characters as a signed decimal
// ----------------------------------------------------------------------------
module gml_axis_scan #(
  parameter int unsigned NumberChars = gml_pkg::NUMBER_CHARS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gml_pkg::BYTE_W-1:0]  axis_letter_i,
  input  logic                        beat_i,
  input  logic [gml_pkg::BYTE_W-1:0]  text_byte_i,
  input  logic                        end_of_line_i,
  input  logic                        col_nonzero_i,
  output gml_pkg::axis_num_t          num_o
);
  import gml_pkg::*;

  localparam int unsigned LEFT_W = $clog2(NumberChars + 1);
  localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(NumberChars);

  logic              seen_q, seen_d;
  logic              neg_q, neg_d;
  logic              point_q, point_d;
  logic              stopped_q, stopped_d;
  logic              started_q, started_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [FRAC_W-1:0] frac_q, frac_d;

  logic [BYTE_W-1:0] up;
  logic              is_digit;
  logic              is_ws;
  logic [ACC_W-1:0]  acc_x10;

  always_comb begin
    up       = to_upper(text_byte_i);
    is_digit = text_byte_i inside {[CHAR_ZERO:CHAR_NINE]};
    is_ws    = text_byte_i inside {CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
    acc_x10  = {acc_q[ACC_W-4:0], 3'b000} + {acc_q[ACC_W-2:0], 1'b0};

    seen_d    = seen_q;
    neg_d     = neg_q;
    point_d   = point_q;
    stopped_d = stopped_q;
    started_d = started_q;
    left_d    = left_q;
    acc_d     = acc_q;
    frac_d    = frac_q;

    if (seen_q) begin
      if (left_q != '0) begin
        if (text_byte_i == CHAR_SPACE) begin
          left_d = '0;
        end else begin
          left_d = left_q - 1'b1;
          if (!stopped_q && !(!started_q && is_ws)) begin
            if (!started_q && (text_byte_i == CHAR_PLUS || text_byte_i == CHAR_MINUS)) begin
              started_d = 1'b1;
              neg_d     = (text_byte_i == CHAR_MINUS);
            end else if (is_digit) begin
              started_d = 1'b1;
              acc_d     = acc_x10 + ACC_W'(text_byte_i[3:0]);
              if (point_q && frac_q != FRAC_MAX) frac_d = frac_q + 1'b1;
            end else if (text_byte_i == CHAR_POINT && !point_q) begin
              started_d = 1'b1;
              point_d   = 1'b1;
            end else begin
              stopped_d = 1'b1;
            end
          end
        end
      end
    end else if (col_nonzero_i && up == axis_letter_i) begin
      seen_d = 1'b1;
      left_d = LEFT_INIT;
    end
  end

  assign num_o = '{seen: seen_d, negative: neg_d, accum: acc_d, frac: frac_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      neg_q     <= 1'b0;
      point_q   <= 1'b0;
      stopped_q <= 1'b0;
      started_q <= 1'b0;
      left_q    <= '0;
      acc_q     <= '0;
      frac_q    <= '0;
    end else if (beat_i) begin
      if (end_of_line_i) begin
        seen_q    <= 1'b0;
        neg_q     <= 1'b0;
        point_q   <= 1'b0;
        stopped_q <= 1'b0;
        started_q <= 1'b0;
        left_q    <= '0;
        acc_q     <= '0;
        frac_q    <= '0;
      end else begin
        seen_q    <= seen_d;
        neg_q     <= neg_d;
        point_q   <= point_d;
        stopped_q <= stopped_d;
        started_q <= started_d;
        left_q    <= left_d;
        acc_q     <= acc_d;
        frac_q    <= frac_d;
      end
    end
  end

endmodule

// ===== rtl/gcode_move_line_parser_core.sv =====
// ----------------------------------------------------------------------------
// gcode_move_line_parser_core
// g1 move-line parser: one text character per beat in, one end point per
// g1 line out
// ----------------------------------------------------------------------------
// path: after the edge taking the line's last character, the move passes the capture,
//   product and output registers before the move beat is valid
// throughput: one character per cycle; ready falls only while capture,
//   product and output registers all hold a move
// reset: held coordinates, line state and all valid flags clear at once
// ----------------------------------------------------------------------------
module gcode_move_line_parser_core #(
  parameter int unsigned NumberChars = gml_pkg::NUMBER_CHARS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gml_in_if.sink      in_i,
  gml_out_if.source   out_o
);
  import gml_pkg::*;

  localparam logic signed [POS_W-1:0] POS_LIM = POS_W'(MAG_MAX);

  logic              beat;
  logic              emit;
  logic [BYTE_W-1:0] up;
  logic [COL_W-1:0]  col_q, col_d;
  logic              move_q, move_d;
  logic              e_q, e_d;
  axis_num_t         num [AXES];

  // capture stage
  logic              v1_q;
  axis_num_t         a1_q [AXES];
  logic              e1_q;

  // product stage
  logic              v2_q;
  logic [PROD_W-1:0] prod2_q [AXES];
  logic [PROD_W-1:0] prod_d  [AXES];
  logic [FRAC_W-1:0] frac2_q [AXES];
  logic              seen2_q [AXES];
  logic              neg2_q  [AXES];
  logic              e2_q;

  // output stage
  logic                    vo_q;
  logic signed [POS_W-1:0] held_q [AXES];
  logic signed [POS_W-1:0] pos_d  [AXES];
  logic                    layer_q;
  logic                    extr_q;

  logic adv1, adv2, out_take;

  assign beat     = in_i.valid && in_i.ready;
  assign out_take = vo_q && out_o.ready;
  assign adv2     = v2_q && (!vo_q || out_o.ready);
  assign adv1     = v1_q && (!v2_q || adv2);
  assign in_i.ready = !(v1_q && v2_q && vo_q);

  always_comb begin
    up     = to_upper(in_i.text_byte);
    move_d = move_q;
    if (col_q == '0) move_d = (up == CHAR_G);
    else if (col_q == COL_ONE) move_d = move_q && (in_i.text_byte == CHAR_ONE);
    e_d   = e_q || (up == CHAR_E);
    col_d = (col_q == COL_SAT) ? col_q : col_q + 1'b1;
    emit  = beat && in_i.end_of_line && move_d && (col_q != '0);
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic [ACC_W:0]    rounded;
    logic [PROD_W-1:0] shifted;
    logic [MAG_W-1:0]  mag;

    gml_axis_scan #(
      .NumberChars (NumberChars)
    ) u_scan (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .axis_letter_i (AXIS_LETTER[a]),
      .beat_i        (beat),
      .text_byte_i   (in_i.text_byte),
      .end_of_line_i (in_i.end_of_line),
      .col_nonzero_i (col_q != '0),
      .num_o         (num[a])
    );

    always_comb begin
      rounded   = {1'b0, a1_q[a].accum} + (ACC_W + 1)'(round_half(a1_q[a].frac));
      prod_d[a] = PROD_W'(rounded) * PROD_W'(scale_mult(a1_q[a].frac));
    end

    always_comb begin
      shifted = prod2_q[a] >> scale_shift(frac2_q[a]);
      mag     = (|shifted[PROD_W-1:MAG_W]) ? MAG_MAX : shifted[MAG_W-1:0];
      if (!seen2_q[a]) pos_d[a] = held_q[a];
      else if (neg2_q[a]) pos_d[a] = '0 - POS_W'({1'b0, mag});
      else pos_d[a] = POS_W'({1'b0, mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      move_q <= 1'b0;
      e_q    <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      vo_q   <= 1'b0;
      for (int a = 0; a < AXES; a++) held_q[a] <= '0;
    end else begin
      if (beat) begin
        if (in_i.end_of_line) begin
          col_q  <= '0;
          move_q <= 1'b0;
          e_q    <= 1'b0;
        end else begin
          col_q  <= col_d;
          move_q <= move_d;
          e_q    <= e_d;
        end
      end
      if (emit) v1_q <= 1'b1;
      else if (adv1) v1_q <= 1'b0;
      if (adv1) v2_q <= 1'b1;
      else if (adv2) v2_q <= 1'b0;
      if (adv2) vo_q <= 1'b1;
      else if (out_take) vo_q <= 1'b0;
      if (adv2) begin
        for (int a = 0; a < AXES; a++) held_q[a] <= pos_d[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      for (int a = 0; a < AXES; a++) a1_q[a] <= num[a];
      e1_q <= e_d;
    end
    if (adv1) begin
      for (int a = 0; a < AXES; a++) begin
        prod2_q[a] <= prod_d[a];
        frac2_q[a] <= a1_q[a].frac;
        seen2_q[a] <= a1_q[a].seen;
        neg2_q[a]  <= a1_q[a].negative;
      end
      e2_q <= e1_q;
    end
    if (adv2) begin
      layer_q <= seen2_q[2];
      extr_q  <= e2_q;
    end
  end

  assign out_o.valid     = vo_q;
  assign out_o.x_pos     = held_q[0];
  assign out_o.y_pos     = held_q[1];
  assign out_o.z_pos     = held_q[2];
  assign out_o.new_layer = layer_q;
  assign out_o.extruding = extr_q;

`ifndef ASSERT_OFF
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && in_i.end_of_line) |=> (col_q == '0 && !move_q && !e_q))
    else $error("line state not cleared after end of line");

  a_move_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> v1_q)
    else $error("move line end not captured");

  a_missing_axis_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv2 && !seen2_q[2]) |=> (out_o.valid && $stable(held_q[2])))
    else $error("absent z changed the held coordinate");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.x_pos >= -POS_LIM && out_o.x_pos <= POS_LIM &&
                     out_o.y_pos >= -POS_LIM && out_o.y_pos <= POS_LIM &&
                     out_o.z_pos >= -POS_LIM && out_o.z_pos <= POS_LIM))
    else $error("coordinate beyond saturation limit");
`endif

endmodule

// ===== dv/gcode_move_line_parser_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcode_move_line_parser_core_tb
// streams g-code text through the parser in bursts while the move channel
// stalls on its own pattern; every move beat is checked field by field
// against a line-by-line software parse of the characters that were taken
// ----------------------------------------------------------------------------
module gcode_move_line_parser_core_tb;
  import gml_pkg::*;

  localparam longint MAG_LIMIT = (64'd1 << MAG_W) - 1;
  localparam logic [BYTE_W-1:0] CHAR_F    = 8'h46;
  localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_HIGH = 8'hFF;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              eol;
  } text_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] z_pos;
    logic                    new_layer;
    logic                    extruding;
  } move_t;

  typedef struct {
    bit                seen;
    bit                negative;
    bit                point;
    bit                stopped;
    bit                started;
    int unsigned       left;
    logic [ACC_W-1:0]  accum;
    logic [FRAC_W-1:0] frac;
  } axis_scan_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gml_in_if  text_if ();
  gml_out_if move_if ();

  gcode_move_line_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_if),
    .out_o  (move_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // line parse state
  longint      held_pos [AXES];
  logic [1:0]  line_col;
  bit          g1_line;
  bit          e_in_line;
  axis_scan_t  axis_state [AXES];

  move_t       expected_moves [$];
  text_beat_t  pending_beats [$];
  logic [7:0]  line_buf [$];
  text_beat_t  next_beat;
  move_t       seen_move;

  int beats_total;
  int beats_taken;
  int fail_count;
  int burst_left;
  int gap_left;
  int stall_run;
  bit ready_level;

  function automatic void clear_line_state();
    int a;
    line_col  = '0;
    g1_line   = 1'b0;
    e_in_line = 1'b0;
    for (a = 0; a < AXES; a++) begin
      axis_state[a].seen     = 1'b0;
      axis_state[a].negative = 1'b0;
      axis_state[a].point    = 1'b0;
      axis_state[a].stopped  = 1'b0;
      axis_state[a].started  = 1'b0;
      axis_state[a].left     = 0;
      axis_state[a].accum    = '0;
      axis_state[a].frac     = '0;
    end
  endfunction

  function automatic void parse_text_byte(input logic [7:0] ch, input logic eol);
    logic [7:0] up;
    logic [1:0] col;
    longint     mag;
    longint     div;
    longint     q;
    longint     r;
    int         a;
    int         k;
    move_t      mv;
    up  = (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) ? ch - CASE_OFFSET : ch;
    col = line_col;
    if (col == 0) g1_line = (up == CHAR_G);
    else if (col == 1) g1_line = g1_line && (ch == CHAR_ONE);
    if (up == CHAR_E) e_in_line = 1'b1;

    for (a = 0; a < AXES; a++) begin
      if (axis_state[a].seen) begin
        if (axis_state[a].left > 0) begin
          if (ch == CHAR_SPACE) begin
            axis_state[a].left = 0;
          end else begin
            axis_state[a].left--;
            // leading whitespace other than space is skipped
            if (!axis_state[a].stopped &&
                (axis_state[a].started || ch < CHAR_TAB || ch > CHAR_CR)) begin
              if (!axis_state[a].started && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
                axis_state[a].started  = 1'b1;
                axis_state[a].negative = (ch == CHAR_MINUS);
              end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                axis_state[a].started = 1'b1;
                axis_state[a].accum   = ACC_W'(axis_state[a].accum * 10 + (ch - CHAR_ZERO));
                if (axis_state[a].point && axis_state[a].frac < FRAC_MAX)
                  axis_state[a].frac++;
              end else if (ch == CHAR_POINT && !axis_state[a].point) begin
                axis_state[a].started = 1'b1;
                axis_state[a].point   = 1'b1;
              end else begin
                axis_state[a].stopped = 1'b1;
              end
            end
          end
        end
      end else if (col > 0 && up == AXIS_LETTER[a]) begin
        axis_state[a].seen = 1'b1;
        axis_state[a].left = NUMBER_CHARS;
      end
    end

    if (line_col < COL_SAT) line_col++;

    if (eol) begin
      if (g1_line && col >= 1) begin
        for (a = 0; a < AXES; a++) begin
          if (axis_state[a].seen) begin
            mag = longint'(axis_state[a].accum);
            if (axis_state[a].frac <= 4) begin
              for (k = axis_state[a].frac; k < 4; k++) mag = mag * 10;
            end else begin
              // more than four fraction digits: round half away from zero
              div = 1;
              for (k = 4; k < axis_state[a].frac; k++) div = div * 10;
              q = mag / div;
              r = mag % div;
              if (2 * r >= div) q++;
              mag = q;
            end
            if (mag > MAG_LIMIT) mag = MAG_LIMIT;
            held_pos[a] = axis_state[a].negative ? -mag : mag;
          end
        end
        mv.x_pos     = held_pos[0][POS_W-1:0];
        mv.y_pos     = held_pos[1][POS_W-1:0];
        mv.z_pos     = held_pos[2][POS_W-1:0];
        mv.new_layer = axis_state[2].seen;
        mv.extruding = e_in_line;
        expected_moves.push_back(mv);
      end
      clear_line_state();
    end
  endfunction

  // line building
  task automatic add_byte(input logic [7:0] b);
    line_buf.push_back(b);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic commit_line();
    text_beat_t b;
    while (line_buf.size() > 0) begin
      b.ch  = line_buf.pop_front();
      b.eol = (line_buf.size() == 0);
      pending_beats.push_back(b);
    end
  endtask

  task automatic add_number();
    logic [7:0] junk [6];
    int         n;
    int         pt;
    int         i;
    junk = '{CHAR_POINT, CHAR_MINUS, CHAR_E | CASE_OFFSET, CHAR_X, CHAR_NUL, CHAR_HIGH};
    if ($urandom_range(0, 7) == 0) add_byte(BYTE_W'(CHAR_TAB + $urandom_range(0, 4)));
    case ($urandom_range(0, 3))
      0:       add_byte(CHAR_PLUS);
      1:       add_byte(CHAR_MINUS);
      default: ;
    endcase
    n  = $urandom_range(0, 6);
    pt = $urandom_range(0, n + 2);
    for (i = 0; i < n; i++) begin
      if (i == pt) add_byte(CHAR_POINT);
      add_byte(BYTE_W'(CHAR_ZERO + $urandom_range(0, 9)));
    end
    if (pt == n) add_byte(CHAR_POINT);
    if ($urandom_range(0, 9) == 0) add_byte(junk[$urandom_range(0, 5)]);
  endtask

  task automatic add_fields(input int nf);
    logic [7:0] letters [7];
    logic [7:0] letter;
    int         f;
    letters = '{CHAR_X, CHAR_Y, CHAR_Z, CHAR_X, CHAR_Y, CHAR_E, CHAR_F};
    for (f = 0; f < nf; f++) begin
      if ($urandom_range(0, 3) != 0) add_byte(CHAR_SPACE);
      letter = letters[$urandom_range(0, 6)];
      if ($urandom_range(0, 2) == 0) letter = letter | CASE_OFFSET;
      add_byte(letter);
      add_number();
    end
  endtask

  task automatic add_random_line();
    int i;
    case ($urandom_range(0, 19))
      0, 1: begin
        add_byte($urandom_range(0, 1) ? CHAR_G : 8'h4D);
        add_byte(BYTE_W'(CHAR_ZERO + $urandom_range(0, 9)));
        add_fields($urandom_range(0, 3));
      end
      2, 3, 4: begin
        if ($urandom_range(0, 1)) add_text("G1");
        for (i = $urandom_range(1, 12); i > 0; i--) add_byte(BYTE_W'($urandom_range(0, 255)));
      end
      default: begin
        add_text($urandom_range(0, 1) ? "G1" : "g1");
        add_fields($urandom_range(0, 4));
        if ($urandom_range(0, 7) == 0) begin
          add_byte(CHAR_SPACE);
          add_byte(CHAR_SEMI);
          add_byte(CHAR_E);
        end
      end
    endcase
    commit_line();
  endtask

  // text driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      text_if.valid       <= 1'b0;
      text_if.text_byte   <= '0;
      text_if.end_of_line <= 1'b0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        parse_text_byte(text_if.text_byte, text_if.end_of_line);
        beats_taken++;
      end
      if (!text_if.valid || text_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          text_if.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          next_beat = pending_beats.pop_front();
          text_if.valid       <= 1'b1;
          text_if.text_byte   <= next_beat.ch;
          text_if.end_of_line <= next_beat.eol;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 120)
                                                   : $urandom_range(0, 12);
            gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7);
          end
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  // move channel stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      move_if.ready <= 1'b0;
    end else begin
      if (stall_run > 0) begin
        stall_run--;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            ready_level = 1'b0;
            stall_run   = $urandom_range(1, 4);
          end
          1: begin
            ready_level = 1'b0;
            stall_run   = $urandom_range(5, 40);
          end
          default: begin
            ready_level = 1'b1;
            stall_run   = $urandom_range(1, 60);
          end
        endcase
      end
      move_if.ready <= ready_level;
    end
  end

  // move checker
  always @(posedge clk_i) begin
    if (rst_ni && move_if.valid && move_if.ready) begin
      if (expected_moves.size() == 0) begin
        $error("move beat with none expected: x_pos %0d y_pos %0d z_pos %0d",
               move_if.x_pos, move_if.y_pos, move_if.z_pos);
        fail_count++;
      end else begin
        seen_move = expected_moves.pop_front();
        if (move_if.x_pos !== seen_move.x_pos) begin
          $error("x_pos: expected %0d, actual %0d", seen_move.x_pos, move_if.x_pos);
          fail_count++;
        end
        if (move_if.y_pos !== seen_move.y_pos) begin
          $error("y_pos: expected %0d, actual %0d", seen_move.y_pos, move_if.y_pos);
          fail_count++;
        end
        if (move_if.z_pos !== seen_move.z_pos) begin
          $error("z_pos: expected %0d, actual %0d", seen_move.z_pos, move_if.z_pos);
          fail_count++;
        end
        if (move_if.new_layer !== seen_move.new_layer) begin
          $error("new_layer: expected %0b, actual %0b", seen_move.new_layer,
                 move_if.new_layer);
          fail_count++;
        end
        if (move_if.extruding !== seen_move.extruding) begin
          $error("extruding: expected %0b, actual %0b", seen_move.extruding,
                 move_if.extruding);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    held_pos            = '{0, 0, 0};
    beats_taken         = 0;
    fail_count          = 0;
    burst_left          = 0;
    gap_left            = 0;
    stall_run           = 0;
    ready_level         = 1'b1;
    clear_line_state();

    // directed lines
    add_text("G");                   commit_line();
    add_text("g1X-99999");           commit_line();
    add_text("G1X99999");            commit_line();
    add_text("G1 x\t+.12 Y1.5.2Ze"); commit_line();
    add_text("G1X1Y2Z3");            commit_line();
    add_text("G1");                  commit_line();
    add_text("G0X5");                commit_line();
    add_text("G1Y-Z+X.");            commit_line();
    add_text("G1X1");
    add_byte(CHAR_NUL);
    add_text("2Y");
    add_byte(8'h80);
    add_text(" Z-3");                commit_line();
    add_text("E");                   commit_line();

    while (pending_beats.size() < 1000) add_random_line();
    beats_total = pending_beats.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (beats_taken == beats_total);
    wait (expected_moves.size() == 0);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** gcode_move_line_parser_core: PASSED **");
    end else begin
      $display("** gcode_move_line_parser_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** gcode_move_line_parser_core: FAILED **");
    $finish;
  end

endmodule
